@@ rtl/occupancy_grid_box_fill_and_sight_core_defines.svh @@
// assertion macros used by the top rtl file of the occupancy grid core
// depends on: nothing; expects clk and rst in the including module
`ifndef OCCUPANCY_GRID_BOX_FILL_AND_SIGHT_CORE_DEFINES_SVH
`define OCCUPANCY_GRID_BOX_FILL_AND_SIGHT_CORE_DEFINES_SVH

// same-cycle implication
`define OGBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OGBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ogbs_pkg.sv @@
// types, codes and helpers of the occupancy grid core
// depends on: nothing
package ogbs_pkg;

  localparam int GRID_ROWS_DEF   = 64;
  localparam int GRID_COLS_DEF   = 64;
  localparam int MAX_SAMPLES_DEF = 1024;

  localparam int COORD_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W   = 20;   // working width of coordinates and indices
  localparam int NUM_W    = 32;   // divider dividend
  localparam int DEN_W    = 20;   // divider divisor

  localparam logic [1:0] CMD_BOX   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_SEG   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd4;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
  } in_item_t;

  typedef struct packed {
    logic       answer;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_CLEAR    = 16'h0002,
    S_BOX_IDX  = 16'h0004,
    S_BOX_DEC  = 16'h0008,
    S_FILL_RD  = 16'h0010,
    S_FILL_WR  = 16'h0020,
    S_SEG_SQ1  = 16'h0040,
    S_SEG_SQ2  = 16'h0080,
    S_SEG_ROOT = 16'h0100,
    S_SEG_CNT  = 16'h0200,
    S_SEG_DIVX = 16'h0400,
    S_SEG_DIVY = 16'h0800,
    S_SEG_STEP = 16'h1000,
    S_LOC_ROW  = 16'h2000,
    S_LOC_COL  = 16'h4000,
    S_LOC_BIT  = 16'h8000
  } state_t;

  function automatic logic signed [WIDE_W-1:0] sx16(input logic [COORD_W-1:0] v);
    return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

@@ rtl/ogbs_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on: ogbs_pkg
module ogbs_div (
  input  logic              clk,
  input  logic              rst,
  input  ogbs_pkg::div_req_t req,
  output ogbs_pkg::div_rsp_t rsp
);
  import ogbs_pkg::*;

  logic                  busy;
  logic                  done;
  logic [4:0]            cnt;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic [NUM_W-1:0]      quo;
  logic [DEN_W:0]        part;
  logic [DEN_W:0]        diff;
  logic                  ge;

  assign part = {rem, quo[NUM_W-1]};
  assign diff = part - {1'b0, den};
  assign ge   = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

@@ rtl/occupancy_grid_box_fill_and_sight_core.sv @@
// top level of the occupancy grid core: sequencer, grid memory, shared units
// depends on: ogbs_pkg, ogbs_div, occupancy_grid_box_fill_and_sight_core_defines.svh
//
// usage
// - command channel: an item (cmd and two points) is taken at a clock edge
//   with start high and busy low; busy stays high until its result is out,
//   except for the unused opcode, which answers in the next cycle, busy low
// - result channel: done strobes for one cycle with answer and status;
//   the receiver cannot stall, so nothing waits on the output side
// - config channel: cfg_ready is always high; write only while busy is low
// - reset: synchronous rst; after it the grid memory is swept to free,
//   one row a cycle, with busy high until the sweep ends
// - point query: row index, column index plus read, bit test (off the grid: no bit test)
// - add box: four index shifts and one decision, then per marked row a read-modify-write
//   of that row through the single memory port pair
// - segment check: multiply, bit-serial square root, sample count, two divisions in
//   the shared divider, then per sample an accumulator step, row index, column index plus
//   read and bit test
// - one item at a time; the next can be taken at the edge that ends the done cycle
`include "occupancy_grid_box_fill_and_sight_core_defines.svh"
module occupancy_grid_box_fill_and_sight_core #(
  parameter int GRID_ROWS   = ogbs_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS   = ogbs_pkg::GRID_COLS_DEF,
  parameter int MAX_SAMPLES = ogbs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  ogbs_pkg::in_item_t                   req,
  output logic                                 busy,
  output logic                                 done,
  output ogbs_pkg::out_item_t                  rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ogbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ogbs_pkg::COORD_W-1:0]         cfg_data
);
  import ogbs_pkg::*;

  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int SW = $clog2(MAX_SAMPLES + 1);

  // config registers
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [3:0]         cell_shift;
  logic [6:0]         rows_in_use;
  logic [6:0]         cols_in_use;

  state_t state;
  in_item_t item_q;

  // grid memory, one row per word
  logic [GRID_COLS-1:0] grid [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data;
  logic                 mem_we;
  logic                 mem_re;
  logic [RW-1:0]        mem_waddr;
  logic [RW-1:0]        mem_raddr;
  logic [GRID_COLS-1:0] mem_wdata;

  // effective map extent
  logic signed [WIDE_W-1:0] eff_rows;
  logic signed [WIDE_W-1:0] eff_cols;

  // shared index shifter
  logic signed [WIDE_W-1:0] sh_in;
  logic signed [WIDE_W-1:0] sh_out;

  // clear sweep
  logic [RW-1:0] clr_row;

  // box fill
  logic [1:0]           box_k;
  logic                 box_rej;
  logic [RW-1:0]        box_r0;
  logic [RW-1:0]        box_r1;
  logic [CW-1:0]        box_c0;
  logic [CW-1:0]        box_c1;
  logic [RW-1:0]        fill_row;
  logic [GRID_COLS-1:0] box_mask;
  logic [GRID_COLS-1:0] box_mask_c;
  logic                 box_rej_all;

  // segment setup
  logic signed [WIDE_W-1:0] dx_c;
  logic signed [WIDE_W-1:0] dy_c;
  logic [15:0]              adx_c;
  logic [15:0]              ady_c;
  logic                     dx_neg;
  logic                     dy_neg;
  logic [15:0]              ady;
  logic [15:0]              adx;
  logic [15:0]              mul_op;
  logic [31:0]              prod;
  logic [31:0]              sqx;

  // square root
  logic [33:0] rad;
  logic [17:0] rt_rem;
  logic [16:0] root;
  logic [4:0]  rt_cnt;
  logic [19:0] rt_sh;
  logic [19:0] rt_trial;

  // sample stepping
  logic [20:0]              ten_len;
  logic [20:0]              n_smp;
  logic [DEN_W-1:0]         den;
  logic [1:0]               seg_status;
  logic [SW-1:0]            smp_lim;
  logic [SW-1:0]            smp_cnt;
  logic signed [WIDE_W-1:0] qstep_x;
  logic signed [WIDE_W-1:0] qstep_y;
  logic [DEN_W-1:0]         rstep_x;
  logic [DEN_W-1:0]         rstep_y;
  logic signed [WIDE_W-1:0] qx;
  logic signed [WIDE_W-1:0] qy;
  logic [DEN_W-1:0]         rx;
  logic [DEN_W-1:0]         ry;
  logic [DEN_W:0]           rsx;
  logic [DEN_W:0]           rsy;
  logic                     gex;
  logic                     gey;
  logic signed [WIDE_W-1:0] qx_n;
  logic signed [WIDE_W-1:0] qy_n;
  logic signed [WIDE_W-1:0] px;
  logic signed [WIDE_W-1:0] py;

  // divider and floor fix-up
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic                     fix_neg;
  logic signed [WIDE_W-1:0] fix_q;
  logic [DEN_W-1:0]         fix_r;

  // cell locate
  logic          row_ok;
  logic          col_in;
  logic [RW-1:0] loc_row;
  logic [CW-1:0] col_idx;
  logic          loc_end;
  logic          loc_blk;

  function automatic logic [RW-1:0] clamp_row(input logic signed [WIDE_W-1:0] v,
                                              input logic signed [WIDE_W-1:0] n);
    logic signed [WIDE_W-1:0] top;
    top = n - WIDE_W'(1);
    if (v < 0) return '0;
    else if (v > top) return top[RW-1:0];
    else return v[RW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_col(input logic signed [WIDE_W-1:0] v,
                                              input logic signed [WIDE_W-1:0] n);
    logic signed [WIDE_W-1:0] top;
    top = n - WIDE_W'(1);
    if (v < 0) return '0;
    else if (v > top) return top[CW-1:0];
    else return v[CW-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // rows and columns in use, clamped to the built grid
  always_comb begin
    if (rows_in_use == '0) eff_rows = WIDE_W'(1);
    else if (WIDE_W'(rows_in_use) > WIDE_W'(GRID_ROWS)) eff_rows = WIDE_W'(GRID_ROWS);
    else eff_rows = WIDE_W'(rows_in_use);
    if (cols_in_use == '0) eff_cols = WIDE_W'(1);
    else if (WIDE_W'(cols_in_use) > WIDE_W'(GRID_COLS)) eff_cols = WIDE_W'(GRID_COLS);
    else eff_cols = WIDE_W'(cols_in_use);
  end

  // one shifter turns a coordinate offset into a floored cell index
  always_comb begin
    sh_in = '0;
    if (state == S_BOX_IDX) begin
      case (box_k)
        2'd0:    sh_in = sx16(origin_y) - sx16(item_q.point_b_y);
        2'd1:    sh_in = sx16(origin_y) - sx16(item_q.point_a_y);
        2'd2:    sh_in = sx16(item_q.point_a_x) - sx16(origin_x);
        default: sh_in = sx16(item_q.point_b_x) - sx16(origin_x);
      endcase
    end else if (state == S_LOC_ROW) begin
      sh_in = sx16(origin_y) - py;
    end else begin
      sh_in = px - sx16(origin_x);
    end
  end
  assign sh_out = sh_in >>> cell_shift;

  // box edges that reject on the raw offset
  assign box_rej_all = box_rej
                    || ((sx16(item_q.point_b_x) - sx16(origin_x)) <= 0)
                    || ((sx16(origin_y) - sx16(item_q.point_a_y)) <= 0);

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      box_mask_c[c] = (CW'(c) >= box_c0) && (CW'(c) <= box_c1);
    end
  end

  // segment deltas and the shared squarer
  assign dx_c  = sx16(item_q.point_b_x) - sx16(item_q.point_a_x);
  assign dy_c  = sx16(item_q.point_b_y) - sx16(item_q.point_a_y);
  assign adx_c = dx_c[WIDE_W-1] ? 16'(-dx_c) : 16'(dx_c);
  assign ady_c = dy_c[WIDE_W-1] ? 16'(-dy_c) : 16'(dy_c);
  assign mul_op = (state == S_SEG_SQ1) ? adx_c : ady;
  assign prod   = mul_op * mul_op;

  // one radicand digit pair per cycle
  assign rt_sh    = {rt_rem, rad[33:32]};
  assign rt_trial = {1'b0, root, 2'b01};

  // samples: ten per cell along the length
  assign ten_len = 21'({root, 3'b000}) + 21'({root, 1'b0});
  assign n_smp   = ten_len >> cell_shift;

  // divider feed: first x offset, then y offset on x done
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {16'b0, adx} << cell_shift;
    div_req.den   = ten_len[DEN_W-1:0];
    if (state == S_SEG_CNT) begin
      div_req.start = (n_smp != '0);
    end else if (state == S_SEG_DIVX) begin
      div_req.start = div_rsp.done;
      div_req.num   = {16'b0, ady} << cell_shift;
      div_req.den   = den;
    end
  end

  ogbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // turn a magnitude quotient into a floored signed one
  always_comb begin
    fix_neg = (state == S_SEG_DIVX) ? dx_neg : dy_neg;
    if (fix_neg && (div_rsp.rem != '0)) begin
      fix_q = -(WIDE_W'(div_rsp.quo) + WIDE_W'(1));
      fix_r = den - div_rsp.rem;
    end else if (fix_neg) begin
      fix_q = -WIDE_W'(div_rsp.quo);
      fix_r = '0;
    end else begin
      fix_q = WIDE_W'(div_rsp.quo);
      fix_r = div_rsp.rem;
    end
  end

  // per-sample quotient and remainder accumulators, one lane per axis
  assign rsx  = {1'b0, rx} + {1'b0, rstep_x};
  assign rsy  = {1'b0, ry} + {1'b0, rstep_y};
  assign gex  = (rsx >= {1'b0, den});
  assign gey  = (rsy >= {1'b0, den});
  assign qx_n = qx + qstep_x + (gex ? WIDE_W'(1) : WIDE_W'(0));
  assign qy_n = qy + qstep_y + (gey ? WIDE_W'(1) : WIDE_W'(0));

  // cell locate: out of the grid counts as blocked
  assign col_in  = !sh_out[WIDE_W-1] && (sh_out < eff_cols);
  assign loc_end = ((state == S_LOC_COL) && !(row_ok && col_in)) || (state == S_LOC_BIT);
  assign loc_blk = (state == S_LOC_BIT) ? rd_data[col_idx] : 1'b1;

  // memory ports
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_FILL_WR);
    mem_waddr = (state == S_CLEAR) ? clr_row : fill_row;
    mem_wdata = (state == S_CLEAR) ? '0 : (rd_data | box_mask);
    mem_re    = (state == S_FILL_RD) || ((state == S_LOC_COL) && row_ok && col_in);
    mem_raddr = (state == S_FILL_RD) ? fill_row : loc_row;
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= grid[mem_raddr];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      cell_shift  <= 4'd4;
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x    <= cfg_data;
        REG_ORIGIN_Y: origin_y    <= cfg_data;
        REG_CELL_SH:  cell_shift  <= cfg_data[3:0];
        REG_ROWS:     rows_in_use <= cfg_data[6:0];
        REG_COLS:     cols_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= req;
            px     <= sx16(req.point_a_x);
            py     <= sx16(req.point_a_y);
            unique case (req.cmd)
              CMD_BOX: begin
                box_k   <= 2'd0;
                box_rej <= 1'b0;
                state   <= S_BOX_IDX;
              end
              CMD_QUERY: state <= S_LOC_ROW;
              CMD_SEG: begin
                seg_status <= ST_OK;
                state      <= S_SEG_SQ1;
              end
              default: begin
                // unknown command answers zero and touches nothing
                done       <= 1'b1;
                rsp.answer <= 1'b0;
                rsp.status <= ST_OK;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_row <= clr_row + RW'(1);
          if (clr_row == RW'(GRID_ROWS - 1)) state <= S_IDLE;
        end
        S_BOX_IDX: begin
          box_k <= box_k + 2'd1;
          case (box_k)
            2'd0: begin
              box_r0 <= clamp_row(sh_out, eff_rows);
              if (sh_out >= eff_rows) box_rej <= 1'b1;
            end
            2'd1: box_r1 <= clamp_row(sh_out, eff_rows);
            2'd2: begin
              box_c0 <= clamp_col(sh_out, eff_cols);
              if (sh_out >= eff_cols) box_rej <= 1'b1;
            end
            default: begin
              box_c1 <= clamp_col(sh_out, eff_cols);
              state  <= S_BOX_DEC;
            end
          endcase
        end
        S_BOX_DEC: begin
          if (box_rej_all) begin
            done       <= 1'b1;
            rsp.answer <= 1'b0;
            rsp.status <= ST_REJECT;
            state      <= S_IDLE;
          end else if ((box_r0 <= box_r1) && (box_c0 <= box_c1)) begin
            box_mask <= box_mask_c;
            fill_row <= box_r0;
            state    <= S_FILL_RD;
          end else begin
            done       <= 1'b1;
            rsp.answer <= 1'b1;
            rsp.status <= ST_OK;
            state      <= S_IDLE;
          end
        end
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: begin
          if (fill_row == box_r1) begin
            done       <= 1'b1;
            rsp.answer <= 1'b1;
            rsp.status <= ST_OK;
            state      <= S_IDLE;
          end else begin
            fill_row <= fill_row + RW'(1);
            state    <= S_FILL_RD;
          end
        end
        S_SEG_SQ1: begin
          sqx    <= prod;
          adx    <= adx_c;
          ady    <= ady_c;
          dx_neg <= dx_c[WIDE_W-1];
          dy_neg <= dy_c[WIDE_W-1];
          state  <= S_SEG_SQ2;
        end
        S_SEG_SQ2: begin
          rad    <= 34'(sqx) + 34'(prod);
          rt_rem <= '0;
          root   <= '0;
          rt_cnt <= '0;
          state  <= S_SEG_ROOT;
        end
        S_SEG_ROOT: begin
          if (rt_sh >= rt_trial) begin
            rt_rem <= 18'(rt_sh - rt_trial);
            root   <= {root[15:0], 1'b1};
          end else begin
            rt_rem <= rt_sh[17:0];
            root   <= {root[15:0], 1'b0};
          end
          rad    <= {rad[31:0], 2'b00};
          rt_cnt <= rt_cnt + 5'd1;
          if (rt_cnt == 5'd16) state <= S_SEG_CNT;
        end
        S_SEG_CNT: begin
          den <= ten_len[DEN_W-1:0];
          if (n_smp > 21'(MAX_SAMPLES)) begin
            smp_lim    <= SW'(MAX_SAMPLES);
            seg_status <= ST_SAT;
          end else begin
            smp_lim <= n_smp[SW-1:0];
          end
          if (n_smp == '0) begin
            // no samples: walkable
            done       <= 1'b1;
            rsp.answer <= 1'b1;
            rsp.status <= ST_OK;
            state      <= S_IDLE;
          end else begin
            state <= S_SEG_DIVX;
          end
        end
        S_SEG_DIVX: begin
          if (div_rsp.done) begin
            qstep_x <= fix_q;
            rstep_x <= fix_r;
            state   <= S_SEG_DIVY;
          end
        end
        S_SEG_DIVY: begin
          if (div_rsp.done) begin
            qstep_y <= fix_q;
            rstep_y <= fix_r;
            qx      <= '0;
            qy      <= '0;
            rx      <= '0;
            ry      <= '0;
            smp_cnt <= '0;
            state   <= S_SEG_STEP;
          end
        end
        S_SEG_STEP: begin
          qx      <= qx_n;
          qy      <= qy_n;
          rx      <= gex ? DEN_W'(rsx - {1'b0, den}) : rsx[DEN_W-1:0];
          ry      <= gey ? DEN_W'(rsy - {1'b0, den}) : rsy[DEN_W-1:0];
          px      <= sx16(item_q.point_a_x) + qx_n;
          py      <= sx16(item_q.point_a_y) + qy_n;
          smp_cnt <= smp_cnt + SW'(1);
          state   <= S_LOC_ROW;
        end
        S_LOC_ROW: begin
          row_ok  <= !sh_out[WIDE_W-1] && (sh_out < eff_rows);
          loc_row <= sh_out[RW-1:0];
          state   <= S_LOC_COL;
        end
        S_LOC_COL: begin
          if (row_ok && col_in) begin
            col_idx <= sh_out[CW-1:0];
            state   <= S_LOC_BIT;
          end
        end
        S_LOC_BIT: ;
        default: state <= S_IDLE;
      endcase

      // end of a cell lookup: query answers, segment stops or steps on
      if (loc_end) begin
        if (item_q.cmd == CMD_QUERY) begin
          done       <= 1'b1;
          rsp.answer <= loc_blk;
          rsp.status <= ST_OK;
          state      <= S_IDLE;
        end else if (loc_blk) begin
          done       <= 1'b1;
          rsp.answer <= 1'b0;
          rsp.status <= seg_status;
          state      <= S_IDLE;
        end else if (smp_cnt == smp_lim) begin
          done       <= 1'b1;
          rsp.answer <= 1'b1;
          rsp.status <= seg_status;
          state      <= S_IDLE;
        end else begin
          state <= S_SEG_STEP;
        end
      end
    end
  end

  `OGBS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while an item is in work")
  `OGBS_ASSERT_NXT(a_accept_busy, start && !busy, busy || done, "item taken but not in work")
  `OGBS_ASSERT_NOW(a_done_after_work, done, $past(busy || start), "result without an item")
  `OGBS_ASSERT_NOW(a_fill_bound, state == S_FILL_WR, fill_row <= box_r1, "box fill past last row")

endmodule

@@ bench/tb_occupancy_grid_box_fill_and_sight_core.sv @@
// self-checking bench for the occupancy grid core: directed table, then random items
// depends on: ogbs_pkg and the occupancy_grid_box_fill_and_sight_core rtl
// each result is compared with a typed row value or a behavioral grid model kept in this module
module tb_occupancy_grid_box_fill_and_sight_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ogbs_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;   // unused opcode, must change nothing
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int NO_IDLE_TAIL = 150;         // last items of the run go back to back
  localparam longint CYCLE_LIMIT = 50000000;

  typedef struct packed {
    in_item_t  it;
    logic      typed;    // 1: use want as typed, else predictor
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t req = '0;
  logic busy, done, cfg_ready;
  out_item_t rsp;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  occupancy_grid_box_fill_and_sight_core dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model copy of the map settings and the grid
  logic signed [15:0] m_ox, m_oy;
  logic [3:0] m_shift;
  logic [6:0] m_rows, m_cols;
  logic [63:0] m_grid [64];

  out_item_t pending_results [$];
  int errs = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;

  // ---------------------------------------------------------------- model
  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint eff_rows();
    if (m_rows < 1) return 1;
    if (m_rows > 64) return 64;
    return m_rows;
  endfunction

  function automatic longint eff_cols();
    if (m_cols < 1) return 1;
    if (m_cols > 64) return 64;
    return m_cols;
  endfunction

  function automatic longint cell_units();
    return longint'(1) << m_shift;
  endfunction

  function automatic longint row_at(longint y);
    return fdiv(longint'(m_oy) - y, cell_units());
  endfunction

  function automatic longint col_at(longint x);
    return fdiv(x - longint'(m_ox), cell_units());
  endfunction

  // outside the grid reads as occupied
  function automatic logic blocked_at(longint x, longint y);
    longint r, c;
    r = row_at(y);
    c = col_at(x);
    if (r < 0 || r >= eff_rows() || c < 0 || c >= eff_cols()) return 1'b1;
    return m_grid[r][c];
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_to(longint v, longint n);
    if (v < 0) return 0;
    if (v > n - 1) return n - 1;
    return v;
  endfunction

  function automatic out_item_t grid_step(in_item_t it);
    out_item_t o;
    longint ax, ay, bx, by, c, left, top, right, bottom, r0, r1, c0, c1;
    longint dx, dy, len, n, den, px, py;
    logic [63:0] mask;
    ax = longint'(it.point_a_x);
    ay = longint'(it.point_a_y);
    bx = longint'(it.point_b_x);
    by = longint'(it.point_b_y);
    c = cell_units();
    o = '0;
    case (it.cmd)
      CMD_BOX: begin
        left = m_ox;
        top = m_oy;
        right = left + eff_cols() * c;
        bottom = top - eff_rows() * c;
        if (ax >= right || by <= bottom || bx <= left || ay >= top) begin
          o.status = ST_REJECT;
        end else begin
          r0 = clamp_to(row_at(by), eff_rows());
          r1 = clamp_to(row_at(ay), eff_rows());
          c0 = clamp_to(col_at(ax), eff_cols());
          c1 = clamp_to(col_at(bx), eff_cols());
          if (r0 <= r1 && c0 <= c1) begin
            mask = '0;
            for (longint k = c0; k <= c1; k++) mask[k] = 1'b1;
            for (longint r = r0; r <= r1; r++) m_grid[r] = m_grid[r] | mask;
          end
          o.answer = 1'b1;
          o.status = ST_OK;
        end
      end
      CMD_QUERY: o.answer = blocked_at(ax, ay);
      CMD_SEG: begin
        dx = bx - ax;
        dy = by - ay;
        len = int_sqrt(dx * dx + dy * dy);
        n = (10 * len) >> m_shift;
        o.answer = 1'b1;
        o.status = ST_OK;
        if (n > 1024) begin
          n = 1024;
          o.status = ST_SAT;
        end
        den = 10 * len;
        for (longint i = 1; i <= n; i++) begin
          px = ax + fdiv(dx * i * c, den);
          py = ay + fdiv(dy * i * c, den);
          if (blocked_at(px, py)) begin
            o.answer = 1'b0;
            break;
          end
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: answer %0d status %0d",
                 $realtime, rsp.answer, rsp.status);
        errs++;
      end else begin
        w = pending_results.pop_front();
        if (rsp.answer !== w.answer) begin
          $display("%0t: answer mismatch: expected %0d actual %0d",
                   $realtime, w.answer, rsp.answer);
          errs++;
        end
        if (rsp.status !== w.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $realtime, w.status, rsp.status);
          errs++;
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // start stays high between back-to-back items; this task drops it only on a gap
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    int gap;
    out_item_t model_out;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req <= it;
    do @(posedge clk); while (busy);
    model_out = grid_step(it);
    if (typed) model_out = want;
    pending_results = {pending_results, model_out};
  endtask

  // block idle and every result in before touching the map settings
  task automatic settle();
    @(negedge clk) start <= 1'b0;
    do @(posedge clk); while (busy || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X: m_ox = val;
      REG_ORIGIN_Y: m_oy = val;
      REG_CELL_SH:  m_shift = val[3:0];
      REG_ROWS:     m_rows = val[6:0];
      REG_COLS:     m_cols = val[6:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_map(logic [15:0] ox, logic [15:0] oy, logic [3:0] sh,
                         logic [6:0] rows, logic [6:0] cols);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELL_SH, {12'd0, sh});
    write_reg(REG_ROWS, {9'd0, rows});
    write_reg(REG_COLS, {9'd0, cols});
  endtask

  function automatic dir_row_t mk(logic [1:0] cmd, int ax, int ay, int bx, int by,
                                  logic typed, logic ans, logic [1:0] st);
    dir_row_t d;
    d.it.cmd = cmd;
    d.it.point_a_x = ax[15:0];
    d.it.point_a_y = ay[15:0];
    d.it.point_b_x = bx[15:0];
    d.it.point_b_y = by[15:0];
    d.typed = typed;
    d.want.answer = ans;
    d.want.status = st;
    return d;
  endfunction

  // coordinates around the current map, a couple of cells past each edge
  function automatic logic [15:0] near_x();
    longint c;
    c = cell_units();
    return 16'(longint'(m_ox) + longint'($urandom_range(0, 32'((eff_cols() + 4) * c)))
               - 2 * c);
  endfunction

  function automatic logic [15:0] near_y();
    longint c;
    c = cell_units();
    return 16'(longint'(m_oy) - longint'($urandom_range(0, 32'((eff_rows() + 4) * c)))
               + 2 * c);
  endfunction

  function automatic logic [15:0] jitter(logic [15:0] v, int cells);
    longint c;
    c = cell_units();
    return 16'(longint'($signed(v)) + longint'($urandom_range(0, 32'(2 * cells * c)))
               - cells * c);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    longint c;
    c = cell_units();
    pick = $urandom_range(0, 99);
    it.point_a_x = near_x();
    it.point_a_y = near_y();
    it.point_b_x = jitter(it.point_a_x, 3);
    it.point_b_y = jitter(it.point_a_y, 3);
    if (pick < 15) begin
      // small box, mostly well ordered
      it.cmd = CMD_BOX;
      it.point_b_x = 16'(longint'($signed(it.point_a_x))
                         + longint'($urandom_range(0, 32'(2 * c))));
      it.point_b_y = 16'(longint'($signed(it.point_a_y))
                         + longint'($urandom_range(0, 32'(2 * c))));
      if ($urandom_range(0, 9) == 0) it.point_b_x = jitter(it.point_a_x, 2);
    end else if (pick < 50) begin
      it.cmd = CMD_QUERY;
    end else if (pick < 92) begin
      it.cmd = CMD_SEG;
    end else if (pick < 95) begin
      // long segment, likely saturating
      it.cmd = CMD_SEG;
      it.point_b_x = 16'($urandom);
      it.point_b_y = 16'($urandom);
    end else if (pick < 97) begin
      it.cmd = CMD_NONE;
      it.point_b_x = 16'($urandom);
    end else begin
      // raw noise on every point field, command query or box
      it.cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_BOX;
      it.point_a_x = 16'($urandom);
      it.point_a_y = 16'($urandom);
      it.point_b_x = 16'($urandom);
      it.point_b_y = 16'($urandom);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- sequence
  initial begin
    dir_row_t dir_tbl [$];
    out_item_t none;
    none = '0;
    m_ox = 0;
    m_oy = 0;
    m_shift = 4;
    m_rows = 64;
    m_cols = 64;
    foreach (m_grid[r]) m_grid[r] = '0;

    // directed rows: defaults give x in [0,1024), y in (-1024,0]
    dir_tbl = {dir_tbl, mk(CMD_QUERY, 0, 0, 0, 0, 1, 1'b0, ST_OK)};       // corner cell free
    dir_tbl = {dir_tbl, mk(CMD_QUERY, -1, -1, 0, 0, 1, 1'b1, ST_OK)};     // off the left edge
    dir_tbl = {dir_tbl, mk(CMD_QUERY, 100, -100, 0, 0, 1, 1'b0, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_BOX, 2000, -50, 2100, -10, 1, 1'b0, ST_REJECT)};   // right of map
    dir_tbl = {dir_tbl, mk(CMD_BOX, 10, 10, 50, 60, 1, 1'b0, ST_REJECT)};         // above map
    dir_tbl = {dir_tbl, mk(CMD_BOX, 16, -48, 47, -17, 1, 1'b1, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_QUERY, 20, -20, 0, 0, 0, 1'b0, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_BOX, 100, -10, 50, -100, 1, 1'b1, ST_OK)};         // inverted box
    dir_tbl = {dir_tbl, mk(CMD_SEG, 500, -500, 500, -500, 1, 1'b1, ST_OK)};       // zero samples
    dir_tbl = {dir_tbl, mk(CMD_SEG, -32768, -32768, 32767, 32767, 1, 1'b0, ST_SAT)};
    dir_tbl = {dir_tbl, mk(CMD_SEG, 600, -600, 900, -900, 0, 1'b0, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_SEG, 0, -32, 100, -32, 0, 1'b0, ST_OK)};          // through box
    dir_tbl = {dir_tbl, mk(CMD_SEG, 700, -700, 1100, -700, 0, 1'b0, ST_OK)};      // leaves map
    dir_tbl = {dir_tbl, mk(CMD_NONE, 1, 2, 3, 4, 1, 1'b0, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_BOX, -100, -30, 20, 40, 0, 1'b0, ST_OK)};          // partial
    dir_tbl = {dir_tbl, mk(CMD_QUERY, 32767, 32767, 0, 0, 1, 1'b1, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_QUERY, -32768, -32768, 0, 0, 1, 1'b1, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_BOX, -32768, -32768, 10, -1000, 1, 1'b1, ST_OK)};  // clamped
    dir_tbl = {dir_tbl, mk(CMD_BOX, 1000, -32768, 32767, 32767, 1, 1'b1, ST_OK)}; // clamped
    dir_tbl = {dir_tbl, mk(CMD_QUERY, 1020, -500, 0, 0, 0, 1'b0, ST_OK)};
    dir_tbl = {dir_tbl, mk(CMD_SEG, 200, -900, 200, -300, 0, 1'b0, ST_OK)};

    // reset, then the block sweeps its grid while busy
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: set_map(16'h8000, 16'h7fff, 4'd0, 7'd1, 7'd1);    // smallest map, far corner
          2: set_map(16'h7fff, 16'h8000, 4'd10, 7'd64, 7'd64); // largest cells
          3: set_map(16'hfc00, 16'h0200, 4'd3, 7'd64, 7'd1);
          default: set_map(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           4'($urandom_range(0, 10)), 7'($urandom_range(1, 64)),
                           7'($urandom_range(1, 64)));
        endcase
      end
      if (p == 0)
        foreach (dir_tbl[k]) send_item(dir_tbl[k].it, dir_tbl[k].typed, dir_tbl[k].want);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        no_idle = (p == NUM_PHASES - 1) && (k >= PHASE_ITEMS - NO_IDLE_TAIL);
        send_item(random_item(), 1'b0, none);
      end
    end

    // drain and let the block go quiet
    @(negedge clk) start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (100) @(posedge clk);
    if (errs == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ogbs_pkg.sv
rtl/ogbs_div.sv
rtl/occupancy_grid_box_fill_and_sight_core.sv
bench/tb_occupancy_grid_box_fill_and_sight_core.sv
